// ===== src/ogcu_pkg.sv =====
// ----------------------------------------------------------------------------
// ogcu_pkg: shared types and constants of the obstacle grid counter update
// Command codes, status codes, register indexes, sequencer states, exp ROM.
// ----------------------------------------------------------------------------
package ogcu_pkg;

  localparam int unsigned GridSideDefault   = 256;
  localparam int unsigned CounterMaxDefault = 10;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_NEW_CELL  = 3'd1,
    ST_DROP_HGT  = 3'd2,
    ST_DROP_GRID = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_READ      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_RES    = 3'd0,
    REG_HLIM   = 3'd1,
    REG_WEIGHT = 3'd2,
    REG_THRESH = 3'd3,
    REG_GSTEP  = 3'd4,
    REG_GMODE  = 3'd5,
    REG_OCCLVL = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCORE_A,
    S_SCORE_B,
    S_SCORE_C,
    S_DIV_X,
    S_DIV_Y,
    S_CHECK,
    S_RD_WAIT,
    S_RD_DATA,
    S_UPDATE,
    S_CLEAR,
    S_READ_WAIT,
    S_READ_DATA,
    S_DONE
  } state_e;

  localparam logic signed [7:0] OccUnknown  = -8'sd1;
  localparam logic signed [7:0] OccFree     = 8'sd0;
  localparam logic signed [7:0] OccOccupied = 8'sd100;

  typedef logic [255:0][16:0] exp_rom_t;

  // 1 - exp(-i/16) in Q0.16, built by the recurrence at elaboration
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t     rom;
    logic [63:0]  e;
    logic [127:0] p;
    e = 64'd1 << 32;
    for (int k = 0; k < 256; k++) begin
      rom[k] = 17'(64'd65536 - ((e + 64'd32768) >> 16));
      p = 128'(e) * 128'd4034748382 + (128'd1 << 31);
      e = p[95:32];
    end
    return rom;
  endfunction

  localparam exp_rom_t ExpRom = build_exp_rom();

endpackage

// ===== src/obstacle_grid_counter_update.sv =====
// ----------------------------------------------------------------------------
// obstacle_grid_counter_update: point scoring and grid counter update
// Sequenced block with one shared restoring divider and a counter store.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o low; its one result shows
// on the result ports for a single cycle with done_o high and cannot be held
// off. A point runs three score steps, then the two divisions of x and y by the
// resolution (one quotient bit a cycle in the shared divider), then a
// read-modify-write of the counter memory. A clear sweeps the valid-bit memory
// one entry a cycle; the same sweep runs after reset, during which busy_o is
// high and which gives no result. Command 3 gives no result.
module obstacle_grid_counter_update #(
  parameter int unsigned GRID_SIDE   = ogcu_pkg::GridSideDefault,
  parameter int unsigned COUNTER_MAX = ogcu_pkg::CounterMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ogcu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ogcu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    cmd_i,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  input  logic signed [31:0]            point_z_i,
  input  logic signed [15:0]            normal_z_i,
  input  logic [15:0]                   read_index_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [15:0]                   cell_index_o,
  output logic [3:0]                    counter_value_o,
  output logic signed [7:0]             occupancy_o,
  output logic [16:0]                   point_score_o,
  output logic signed [7:0]             min_cell_x_o,
  output logic signed [7:0]             min_cell_y_o
);
  import ogcu_pkg::*;

  localparam int unsigned Cells = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned SW    = $clog2(GRID_SIDE);
  localparam int unsigned Half  = GRID_SIDE / 2;
  localparam logic [3:0]  CntMax = 4'(COUNTER_MAX);

  // configuration registers
  logic [30:0]        res_q;
  logic signed [31:0] hlim_q;
  logic [16:0]        weight_q, thresh_q;
  logic [3:0]         gstep_q, occlvl_q;
  logic               gmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q    <= 31'd3277;
      hlim_q   <= 32'sd131072;
      weight_q <= 17'd32768;
      thresh_q <= 17'd32768;
      gstep_q  <= 4'd1;
      gmode_q  <= 1'b0;
      occlvl_q <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RES:    res_q    <= cfg_data_i[30:0];
        REG_HLIM:   hlim_q   <= cfg_data_i;
        REG_WEIGHT: weight_q <= cfg_data_i[16:0];
        REG_THRESH: thresh_q <= cfg_data_i[16:0];
        REG_GSTEP:  gstep_q  <= cfg_data_i[3:0];
        REG_GMODE:  gmode_q  <= cfg_data_i[0];
        REG_OCCLVL: occlvl_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_e state_q, state_d;
  logic signed [31:0] x_q, y_q, z_q;
  logic signed [15:0] nz_q;
  logic [15:0] ridx_q;
  logic [16:0] pn_q, pz_q, s_q, score_q;
  logic [33:0] prod_q;
  logic [AW-1:0] sweep_q;
  logic        boot_q;
  logic signed [8:0] least_x_q, least_y_q;

  // shared divider: |v| / r, one quotient bit a cycle
  logic [31:0] dvd_q;
  logic [31:0] rem_q;
  logic [5:0]  dcnt_q;
  logic        dneg_q;
  logic signed [33:0] cx_q;
  logic [31:0] rem_sh;
  logic [31:0] rdiv;
  logic        rem_ge;
  assign rdiv   = (res_q == '0) ? 32'd1 : {1'b0, res_q};
  assign rem_sh = {rem_q[30:0], dvd_q[31]};
  assign rem_ge = {rem_q[31], rem_sh} >= {1'b0, rdiv};

  // floor(v/r)+1 from unsigned magnitude quotient and remainder
  function automatic logic signed [33:0] floor_cell(input logic [31:0] q,
      input logic [31:0] rm, input logic neg);
    logic signed [33:0] qs;
    qs = $signed({2'b00, q});
    if (neg) qs = -qs - ((rm != '0) ? 34'sd1 : 34'sd0);
    return qs + 34'sd1;
  endfunction

  logic signed [33:0] cy_w;
  assign cy_w = floor_cell(dvd_q, rem_q, dneg_q);

  logic off_x, off_y;
  assign off_x = (cx_q < -$signed(34'(Half))) || (cx_q > $signed(34'(GRID_SIDE - Half - 1)));
  assign off_y = (cy_w < -$signed(34'(Half))) || (cy_w > $signed(34'(GRID_SIDE - Half - 1)));

  // cell coordinates shifted to the grid origin
  logic [SW-1:0] xoff, yoff;
  assign xoff = SW'(cx_q + 34'(Half));
  assign yoff = SW'(cy_w + 34'(Half));

  // memories: valid bits and counters, read data registered
  logic          valid_mem [Cells];
  logic [3:0]    cnt_mem   [Cells];
  logic [AW-1:0] addr_q;
  logic          vrd_q;
  logic [3:0]    crd_q;
  logic          v_we, c_we, v_wd;
  logic [AW-1:0] v_wa;
  logic [3:0]    c_wd;

  always_ff @(posedge clk_i) begin
    if (v_we) valid_mem[v_wa] <= v_wd;
    if (c_we) cnt_mem[addr_q] <= c_wd;
    vrd_q <= valid_mem[addr_q];
    crd_q <= cnt_mem[addr_q];
  end

  // counter update arithmetic
  logic [3:0] step;
  logic       hit;
  logic [4:0] sum;
  logic [3:0] new_cnt;
  assign step = gmode_q ? gstep_q : 4'd1;
  assign hit  = score_q >= thresh_q;
  assign sum  = {1'b0, crd_q} + {1'b0, step};
  always_comb begin
    if (!vrd_q) new_cnt = hit ? ((step > CntMax) ? CntMax : step) : 4'd0;
    else if (hit) new_cnt = (sum > {1'b0, CntMax}) ? CntMax : sum[3:0];
    else new_cnt = (crd_q > step) ? crd_q - step : 4'd0;
  end

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);
  assign v_we = (state_q == S_CLEAR) || (state_q == S_UPDATE && !vrd_q);
  assign v_wa = (state_q == S_CLEAR) ? sweep_q : addr_q;
  assign v_wd = (state_q != S_CLEAR);
  assign c_we = (state_q == S_UPDATE);
  assign c_wd = new_cnt;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) begin
        unique case (cmd_e'(cmd_i))
          CMD_POINT: state_d = S_SCORE_A;
          CMD_CLEAR: state_d = S_CLEAR;
          CMD_READ:  state_d = S_READ_WAIT;
          default:   state_d = S_IDLE;
        endcase
      end
      S_SCORE_A: state_d = (z_q > hlim_q) ? S_DONE : S_SCORE_B;
      S_SCORE_B: state_d = S_SCORE_C;
      S_SCORE_C: state_d = S_DIV_X;
      S_DIV_X:   if (dcnt_q == 6'd32) state_d = S_DIV_Y;
      S_DIV_Y:   if (dcnt_q == 6'd32) state_d = S_CHECK;
      S_CHECK:   state_d = (off_x || off_y) ? S_DONE : S_RD_WAIT;
      S_RD_WAIT: state_d = S_RD_DATA;
      S_RD_DATA: state_d = S_UPDATE;
      S_UPDATE:  state_d = S_DONE;
      S_CLEAR:   if (sweep_q == AW'(Cells - 1)) state_d = boot_q ? S_IDLE : S_DONE;
      S_READ_WAIT: state_d = S_READ_DATA;
      S_READ_DATA: state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  logic [15:0] nabs;
  logic [31:0] zabs;
  assign nabs = normal_z_i[15] ? 16'(-normal_z_i) : normal_z_i;
  assign zabs = z_q[31] ? 32'(-z_q) : z_q;

  // result registers
  logic       done_q;
  status_e    status_q;
  logic [15:0] idx_q;
  logic [3:0] cntv_q;
  logic signed [7:0] occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= '0;
      boot_q    <= 1'b1;
      least_x_q <= '0;
      least_y_q <= '0;
      done_q    <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      done_q <= (state_q == S_DONE);
      unique case (state_q)
        S_IDLE: begin
          sweep_q <= '0;
          boot_q  <= 1'b0;
          if (accept) begin
            x_q    <= point_x_i;
            y_q    <= point_y_i;
            z_q    <= point_z_i;
            nz_q   <= (nabs > 16'd16384) ? 16'd16384 : nabs;
            ridx_q <= read_index_i;
            addr_q <= AW'(read_index_i);
            score_q <= '0;
            idx_q  <= '0;
            cntv_q <= '0;
            occ_q  <= OccFree;
            status_q <= ST_CLEARED;
          end
        end
        S_SCORE_A: begin
          status_q <= ST_DROP_HGT;
          pn_q <= 17'((16'd16384 - nz_q) * 4);
          pz_q <= (zabs[31:20] == '0) ? ExpRom[zabs[19:12]] : 17'd65536;
          s_q  <= (weight_q > 17'd65536) ? 17'd65536 : weight_q;
        end
        S_SCORE_B: prod_q <= 34'(s_q) * 34'(pn_q) + 34'd32768;
        S_SCORE_C: begin
          score_q <= 17'((prod_q + 34'(17'd65536 - s_q) * 34'(pz_q)) >> 16);
          dvd_q  <= x_q[31] ? 32'(-x_q) : x_q;
          dneg_q <= x_q[31];
          rem_q  <= '0;
          dcnt_q <= '0;
        end
        S_DIV_X, S_DIV_Y: begin
          if (dcnt_q == 6'd32) begin
            // keep x cell and load y; hold y result for the check
            if (state_q == S_DIV_X) begin
              cx_q   <= cy_w;
              dvd_q  <= y_q[31] ? 32'(-y_q) : y_q;
              dneg_q <= y_q[31];
              rem_q  <= '0;
              dcnt_q <= '0;
            end
          end else begin
            rem_q  <= rem_ge ? 32'({rem_q[31], rem_sh} - {1'b0, rdiv}) : rem_sh;
            dvd_q  <= {dvd_q[30:0], rem_ge};
            dcnt_q <= dcnt_q + 6'd1;
          end
        end
        S_CHECK: begin
          status_q <= ST_DROP_GRID;
          addr_q <= AW'(yoff * GRID_SIDE + xoff);
        end
        S_RD_DATA: ;
        S_UPDATE: begin
          idx_q  <= 16'(addr_q);
          cntv_q <= new_cnt;
          status_q <= vrd_q ? ST_UPDATED : ST_NEW_CELL;
          if (!vrd_q) begin
            if (cx_q < 34'(least_x_q)) least_x_q <= cx_q[8:0];
            if (cy_w < 34'(least_y_q)) least_y_q <= cy_w[8:0];
          end
        end
        S_CLEAR: begin
          sweep_q <= sweep_q + 1'b1;
          least_x_q <= '0;
          least_y_q <= '0;
        end
        S_READ_DATA: begin
          status_q <= ST_READ;
          idx_q <= ridx_q;
          if (32'(ridx_q) < Cells && vrd_q) begin
            cntv_q <= crd_q;
            occ_q  <= (crd_q != 0 && crd_q > occlvl_q) ? OccOccupied : OccFree;
          end else begin
            occ_q <= OccUnknown;
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign cell_index_o    = idx_q;
  assign counter_value_o = cntv_q;
  assign occupancy_o     = occ_q;
  assign point_score_o   = score_q;
  assign min_cell_x_o    = least_x_q[7:0];
  assign min_cell_y_o    = least_y_q[7:0];

  // checks
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat longer than one cycle");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  a_minx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    least_x_q <= 0) else $error("least x above zero");
  a_miny: assert property (@(posedge clk_i) disable iff (!rst_ni)
    least_y_q <= 0) else $error("least y above zero");

endmodule
